>>> sv/chash_pkg.sv
package chash_pkg;

  localparam int SLOT_BITS = 8;
  localparam int SLOTS     = 1 << SLOT_BITS;
  localparam int LINK_W    = SLOT_BITS + 1;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [LINK_W-1:0]    link_t;

  localparam link_t LINK_FREE = '1;
  localparam link_t LINK_END  = LINK_FREE - link_t'(1);
  localparam int    FLAG_BIT  = SLOT_BITS;
  localparam link_t LAST_STEP = link_t'(SLOTS - 1);
  localparam link_t FULL_CNT  = link_t'(SLOTS);

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // one write into the slot store
  typedef struct packed {
    logic        en_link;
    logic        en_data;
    slot_t       addr;
    link_t       link;
    logic [31:0] key;
    logic [31:0] val;
    slot_t       home;
  } wr_t;

  // registered read of one slot
  typedef struct packed {
    link_t       link;
    logic [31:0] key;
    logic [31:0] val;
    slot_t       home;
  } rd_t;

endpackage

>>> sv/chash_mem.sv
module chash_mem import chash_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  slot_t raddr,
  input  wr_t   wr,
  output rd_t   rd
);

  link_t       link_mem [SLOTS];
  logic [31:0] key_mem  [SLOTS];
  logic [31:0] val_mem  [SLOTS];
  slot_t       home_mem [SLOTS];
  logic [SLOTS-1:0] vld;

  link_t       link_q;
  logic        vld_q;
  logic [31:0] key_q;
  logic [31:0] val_q;
  slot_t       home_q;

  // valid bits: an unwritten link reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en_link) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr.en_link) begin
      link_mem[wr.addr] <= wr.link;
    end
    if (wr.en_data) begin
      key_mem[wr.addr]  <= wr.key;
      val_mem[wr.addr]  <= wr.val;
      home_mem[wr.addr] <= wr.home;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    link_q <= link_mem[raddr];
    vld_q  <= vld[raddr];
    key_q  <= key_mem[raddr];
    val_q  <= val_mem[raddr];
    home_q <= home_mem[raddr];
  end

  assign rd.link = vld_q ? link_q : LINK_FREE;
  assign rd.key  = key_q;
  assign rd.val  = val_q;
  assign rd.home = home_q;

endmodule

>>> sv/chash_ctrl.sv
module chash_ctrl import chash_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  req_type,
  input  logic [31:0] key,
  input  slot_t       home_bucket,
  input  logic [31:0] value,
  input  rd_t         rd,
  output slot_t       raddr,
  output wr_t         wr,
  output logic        busy,
  output logic        done,
  output logic [2:0]  status,
  output slot_t       slot,
  output logic [31:0] stored_value,
  output link_t       fill_count
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_LOOK  = 11'b00000000100,
    S_RMNX  = 11'b00000001000,
    S_INS0  = 11'b00000010000,
    S_REL   = 11'b00000100000,
    S_SCAN  = 11'b00001000000,
    S_CHN   = 11'b00010000000,
    S_CHN2  = 11'b00100000000,
    S_WRITE = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t      state, ret;
  slot_t       ra, idx, prv, ref_slot;
  logic        prv_ok, ref_ok, up;
  link_t       n, cnt;
  logic [1:0]  typ;
  logic [31:0] kq, vq, dk, dv;
  slot_t       hq, dh;
  link_t       dl;
  wr_t         w0, w1, w2;
  slot_t       step_in, step_out;
  logic        step_up;

  // shared slot stepper for the free-slot scans and their start slots
  assign step_out = step_up ? step_in + slot_t'(1) : step_in - slot_t'(1);

  assign raddr      = ra;
  assign wr         = w0;
  assign busy       = (state != S_IDLE);
  assign done       = (state == S_DONE);
  assign fill_count = cnt;

  function automatic wr_t link_wr(slot_t a, link_t l);
    wr_t w;
    w = '0;
    w.en_link = 1'b1;
    w.addr = a;
    w.link = l;
    return w;
  endfunction

  function automatic wr_t full_wr(slot_t a, link_t l, logic [31:0] k, logic [31:0] v,
                                  slot_t h);
    wr_t w;
    w.en_link = 1'b1;
    w.en_data = 1'b1;
    w.addr = a;
    w.link = l;
    w.key = k;
    w.val = v;
    w.home = h;
    return w;
  endfunction

  // stepper input selection
  always_comb begin
    step_in = ra;
    step_up = up;
    case (state)
      S_REL: begin
        step_in = (rd.link == {1'b0, hq}) ? idx : hq;
        step_up = 1'b0;
      end
      S_CHN, S_CHN2: begin
        step_in = (state == S_CHN2 && rd.link != LINK_FREE) ? ra : idx;
        step_up = 1'b1;
      end
      default: begin
        step_in = ra;
        step_up = up;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      cnt   <= '0;
      w0    <= '0;
      w1    <= '0;
      w2    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            typ <= req_type;
            kq <= key;
            vq <= value;
            hq <= home_bucket;
            ra <= home_bucket;
            idx <= home_bucket;
            n <= '0;
            prv_ok <= 1'b0;
            ref_ok <= 1'b0;
            status <= ST_NOTFOUND;
            slot <= '0;
            stored_value <= '0;
            if (req_type == REQ_INSERT && cnt >= FULL_CNT) begin
              status <= ST_FULL;
              state <= S_DONE;
            end else if (req_type == REQ_INSERT) begin
              ret <= S_INS0;
              state <= S_RD;
            end else if (req_type == REQ_LOOKUP || req_type == REQ_REMOVE) begin
              ret <= S_LOOK;
              state <= S_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RD: state <= ret;
        // chain walk for lookup and remove
        S_LOOK: begin
          if (rd.link != LINK_FREE && rd.key == kq) begin
            if (typ == REQ_LOOKUP) begin
              status <= ST_FOUND;
              slot <= idx;
              stored_value <= rd.val;
              state <= S_DONE;
            end else begin
              status <= ST_REMOVED;
              if (prv_ok) begin
                w0 <= link_wr(prv, rd.link);
                w1 <= link_wr(idx, LINK_FREE);
                if (cnt != '0) cnt <= cnt - link_t'(1);
                state <= S_WRITE;
              end else if (!rd.link[FLAG_BIT]) begin
                ra <= rd.link[SLOT_BITS-1:0];
                ret <= S_RMNX;
                state <= S_RD;
              end else begin
                w0 <= link_wr(idx, LINK_FREE);
                if (cnt != '0) cnt <= cnt - link_t'(1);
                state <= S_WRITE;
              end
            end
          end else begin
            prv <= idx;
            prv_ok <= 1'b1;
            if (rd.link[FLAG_BIT] || n == LAST_STEP) begin
              state <= S_DONE;
            end else begin
              idx <= rd.link[SLOT_BITS-1:0];
              ra <= rd.link[SLOT_BITS-1:0];
              n <= n + link_t'(1);
              state <= S_RD;
            end
          end
        end
        // pull the second element up into the head slot
        S_RMNX: begin
          w0 <= full_wr(idx, rd.link, rd.key, rd.val, rd.home);
          w1 <= link_wr(ra, LINK_FREE);
          if (cnt != '0) cnt <= cnt - link_t'(1);
          state <= S_WRITE;
        end
        // insert: inspect the home slot
        S_INS0: begin
          if (rd.link == LINK_FREE) begin
            w0 <= full_wr(hq, LINK_END, kq, vq, hq);
            status <= ST_INSERTED;
            slot <= hq;
            cnt <= cnt + link_t'(1);
            state <= S_WRITE;
          end else if (rd.home != hq) begin
            dk <= rd.key;
            dv <= rd.val;
            dh <= rd.home;
            dl <= rd.link;
            ra <= rd.home;
            idx <= rd.home;
            ret <= S_REL;
            state <= S_RD;
          end else begin
            state <= S_CHN;
          end
        end
        // find the predecessor of the displaced entry
        S_REL: begin
          if (rd.link == {1'b0, hq}) begin
            ref_slot <= idx;
            ref_ok <= 1'b1;
          end
          if (rd.link == {1'b0, hq} || rd.link[FLAG_BIT] || n == LAST_STEP) begin
            up <= 1'b0;
            n <= '0;
            ra <= step_out;
            ret <= S_SCAN;
            state <= S_RD;
          end else begin
            idx <= rd.link[SLOT_BITS-1:0];
            ra <= rd.link[SLOT_BITS-1:0];
            n <= n + link_t'(1);
            state <= S_RD;
          end
        end
        // free-slot scan, one slot per read
        S_SCAN: begin
          if (rd.link == LINK_FREE) begin
            status <= ST_INSERTED;
            cnt <= cnt + link_t'(1);
            state <= S_WRITE;
            if (up) begin
              w0 <= link_wr(idx, {1'b0, ra});
              w1 <= full_wr(ra, LINK_END, kq, vq, hq);
              slot <= ra;
            end else begin
              // writes queue back to back; no empty entry in between
              w0 <= full_wr(ra, dl, dk, dv, dh);
              w1 <= ref_ok ? link_wr(ref_slot, {1'b0, ra}) : full_wr(hq, LINK_END, kq, vq, hq);
              w2 <= ref_ok ? full_wr(hq, LINK_END, kq, vq, hq) : '0;
              slot <= hq;
            end
          end else if (n == LAST_STEP) begin
            status <= ST_FULL;
            state <= S_DONE;
          end else begin
            n <= n + link_t'(1);
            ra <= step_out;
            state <= S_RD;
          end
        end
        // insert: duplicate search along own chain
        S_CHN: begin
          if (rd.key == kq) begin
            status <= ST_PRESENT;
            slot <= idx;
            stored_value <= rd.val;
            state <= S_DONE;
          end else if (rd.link[FLAG_BIT]) begin
            up <= 1'b1;
            n <= '0;
            ra <= step_out;
            ret <= S_SCAN;
            state <= S_RD;
          end else begin
            ra <= rd.link[SLOT_BITS-1:0];
            ret <= S_CHN2;
            state <= S_RD;
          end
        end
        S_CHN2: begin
          if (rd.link == LINK_FREE || n == LAST_STEP) begin
            if (rd.link != LINK_FREE) idx <= ra;
            up <= 1'b1;
            n <= '0;
            ra <= step_out;
            ret <= S_SCAN;
            state <= S_RD;
          end else begin
            idx <= ra;
            n <= n + link_t'(1);
            state <= S_CHN;
          end
        end
        // drain queued writes
        S_WRITE: begin
          w0 <= w1;
          w1 <= w2;
          w2 <= '0;
          if (!(w1.en_link || w1.en_data)) state <= S_DONE;
        end
        S_DONE: begin
          w0 <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/coalesced_hash_table.sv
// Channel | Ports                                  | Handshake
// request | req_type, key, home_bucket, value      | start high, busy low
// result  | status, slot, stored_value, fill_count | done, one cycle
// One item at a time; busy stays high until its result is shown.
// Each chain walk, duplicate search or free-slot scan step waits on a registered
// read of the slot store, and queued store writes drain one at a time.
// Reset clears control and the link valid bits at once; no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle.
module coalesced_hash_table import chash_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] key,
  input  logic [7:0]  home_bucket,
  input  logic [31:0] value,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  slot,
  output logic [31:0] stored_value,
  output logic [8:0]  fill_count
);

  slot_t raddr;
  wr_t   wr;
  rd_t   rd;

  chash_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .raddr (raddr),
    .wr    (wr),
    .rd    (rd)
  );

  chash_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_type     (req_type),
    .key          (key),
    .home_bucket  (home_bucket),
    .value        (value),
    .rd           (rd),
    .raddr        (raddr),
    .wr           (wr),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .stored_value (stored_value),
    .fill_count   (fill_count)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after result");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item not worked on");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_CNT)
    else $error("fill count beyond table size");

endmodule
